// ===== sv/rid_pkg.sv =====
// Shared opcodes, status codes and the command record passed from front to back.
`default_nettype none
package rid_pkg;

   // Fixed field widths of the request and response beats
   localparam int OPCODE_W = 4;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   // Default capacity and command queue depth
   localparam int DEPTH_DEFAULT = 1024;
   localparam int CMDQ_DEPTH    = 4;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH_LEFT  = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_RIGHT = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_LEFT   = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_RIGHT  = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_PEEK_LEFT  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_PEEK_RIGHT = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_GET        = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_SET        = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_REVERSE    = 4'd8;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // Store access that the back end performs for one beat
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_READ,
      KIND_WRITE
   } mem_kind_type;

   // Control part of one queued command
   typedef struct packed {
      mem_kind_type         kind;
      logic [STATUS_W-1:0]  status;
      logic [COUNT_W-1:0]   count;
      logic                 is_empty;
   } cmd_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/reversible_indexed_deque_core.sv =====
// Top level of the reversible indexed deque: front end, command queue and back end.
`default_nettype none
// A bounded deque of DEPTH signed 64-bit values held in a ring buffer, with
// push, pop and peek at either end, get and set by index from the logical
// left, and a reverse operation that swaps left and right. Every request beat
// yields exactly one response beat with data, status, count and an empty flag.
// The front end updates pointer, count and orientation as it accepts a beat,
// so a new request is accepted every cycle while the command queue has room;
// the single-port element store in the back end does at most one read or
// write per beat. An accepted request is written into the command queue; the
// back end then registers the store read and the response, raising rsp_valid.
// A four-entry command queue separates the two ends, so request acceptance
// stalls only when that queue is full. The store needs no clearing after reset.
module reversible_indexed_deque_core #(
   parameter int DEPTH = rid_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [rid_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [rid_pkg::INDEX_W-1:0]   req_index,
   input  wire logic [rid_pkg::VALUE_W-1:0]   req_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [rid_pkg::VALUE_W-1:0]   rsp_data,
   output      logic [rid_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [rid_pkg::COUNT_W-1:0]   rsp_count,
   output      logic                          rsp_is_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CW    = rid_pkg::COUNT_W;

   logic                         fq_valid;
   logic                         fq_full;
   rid_pkg::cmd_ctrl_type        fq_ctrl;
   logic [PTR_W-1:0]             fq_addr;
   logic [rid_pkg::VALUE_W-1:0]  fq_value;
   logic                         qb_valid;
   logic                         qb_take;
   rid_pkg::cmd_ctrl_type        qb_ctrl;
   logic [PTR_W-1:0]             qb_addr;
   logic [rid_pkg::VALUE_W-1:0]  qb_value;

   rid_front #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_index  (req_index),
      .req_value  (req_value),
      .cmd_full   (fq_full),
      .cmd_valid  (fq_valid),
      .cmd_ctrl   (fq_ctrl),
      .cmd_addr   (fq_addr),
      .cmd_value  (fq_value)
   );

   rid_cmdq #(
      .PTR_W (PTR_W)
   ) u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_full  (fq_full),
      .wr_ctrl  (fq_ctrl),
      .wr_addr  (fq_addr),
      .wr_value (fq_value),
      .rd_valid (qb_valid),
      .rd_take  (qb_take),
      .rd_ctrl  (qb_ctrl),
      .rd_addr  (qb_addr),
      .rd_value (qb_value)
   );

   rid_back #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (qb_valid),
      .cmd_take     (qb_take),
      .cmd_ctrl     (qb_ctrl),
      .cmd_addr     (qb_addr),
      .cmd_value    (qb_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   // Any error beat carries all-ones data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rid_pkg::ST_OK) |-> (rsp_data == '1))
      else $error("error response without all-ones data");

   // A dropped push only happens at full capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rid_pkg::ST_FULL) |-> (rsp_count == CW'(DEPTH)))
      else $error("full status with count below capacity");

   // The empty flag follows the reported count whenever DEPTH fits the count field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 2047) || (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // An empty status never reports stored elements
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rid_pkg::ST_EMPTY) |-> rsp_is_empty)
      else $error("empty status while elements are held");

endmodule
`default_nettype wire

// ===== sv/rid_front.sv =====
// Front end: decodes request beats, keeps pointer, count and orientation, issues commands.
`default_nettype none
module rid_front #(
   parameter int DEPTH = rid_pkg::DEPTH_DEFAULT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [rid_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [rid_pkg::INDEX_W-1:0]   req_index,
   input  wire logic [rid_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                          cmd_full,
   output      logic                          cmd_valid,
   output      rid_pkg::cmd_ctrl_type         cmd_ctrl,
   output      logic [PTR_W-1:0]              cmd_addr,
   output      logic [rid_pkg::VALUE_W-1:0]   cmd_value
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CW     = rid_pkg::COUNT_W;
   localparam int WIDE_W = (CNT_W > rid_pkg::INDEX_W) ? CNT_W : rid_pkg::INDEX_W;

   logic [PTR_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rev_ff, rev_in;

   logic               accept;
   logic               side;
   logic               is_full;
   logic               is_empty;
   logic               range_err;
   logic [PTR_W-1:0]   front_dec;
   logic [PTR_W-1:0]   front_inc;
   logic [WIDE_W-1:0]  idx_w;
   logic [WIDE_W-1:0]  cnt_w;
   logic [WIDE_W-1:0]  abs_w;
   logic [CNT_W-1:0]   count_m1;
   logic [PTR_W-1:0]   pos;
   logic               use_direct;
   logic [PTR_W-1:0]   direct_addr;
   logic [PTR_W:0]     slot_sum;
   rid_pkg::mem_kind_type   kind;
   logic [rid_pkg::STATUS_W-1:0] status;

   // Stall while the command queue has no room
   assign req_stall = cmd_full;
   assign accept    = req_valid & ~cmd_full;

   // Classify against the current state
   assign side      = req_opcode[0] ^ rev_ff;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == PTR_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign count_m1  = count_ff - 1'b1;
   assign idx_w     = WIDE_W'(req_index);
   assign cnt_w     = WIDE_W'(count_ff);
   assign range_err = (idx_w >= cnt_w);
   assign abs_w     = rev_ff ? (cnt_w - 1'b1 - idx_w) : idx_w;

   // Work out the next state and the store access of this beat
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      rev_in      = rev_ff;
      kind        = rid_pkg::KIND_NONE;
      status      = rid_pkg::ST_OK;
      pos         = PTR_W'(count_ff);
      use_direct  = 1'b0;
      direct_addr = front_ff;
      case (req_opcode)
         rid_pkg::OP_PUSH_LEFT, rid_pkg::OP_PUSH_RIGHT: begin
            if (is_full) begin
               status = rid_pkg::ST_FULL;
            end else begin
               kind     = rid_pkg::KIND_WRITE;
               count_in = count_ff + 1'b1;
               if (!side) begin
                  front_in    = front_dec;
                  use_direct  = 1'b1;
                  direct_addr = front_dec;
               end else begin
                  pos = PTR_W'(count_ff);
               end
            end
         end
         rid_pkg::OP_POP_LEFT, rid_pkg::OP_POP_RIGHT: begin
            if (is_empty) begin
               status = rid_pkg::ST_EMPTY;
            end else begin
               kind     = rid_pkg::KIND_READ;
               count_in = count_m1;
               if (!side) begin
                  front_in    = front_inc;
                  use_direct  = 1'b1;
                  direct_addr = front_ff;
               end else begin
                  pos = PTR_W'(count_m1);
               end
            end
         end
         rid_pkg::OP_PEEK_LEFT, rid_pkg::OP_PEEK_RIGHT: begin
            if (is_empty) begin
               status = rid_pkg::ST_EMPTY;
            end else begin
               kind = rid_pkg::KIND_READ;
               if (!side) begin
                  use_direct  = 1'b1;
                  direct_addr = front_ff;
               end else begin
                  pos = PTR_W'(count_m1);
               end
            end
         end
         rid_pkg::OP_GET, rid_pkg::OP_SET: begin
            if (is_empty) begin
               status = rid_pkg::ST_EMPTY;
            end else if (range_err) begin
               status = rid_pkg::ST_RANGE;
            end else begin
               kind = (req_opcode == rid_pkg::OP_GET) ? rid_pkg::KIND_READ
                                                      : rid_pkg::KIND_WRITE;
               pos  = PTR_W'(abs_w);
            end
         end
         rid_pkg::OP_REVERSE: begin
            rev_in = ~rev_ff;
         end
         default: begin
            kind = rid_pkg::KIND_NONE;
         end
      endcase
   end

   // Map an absolute position onto its ring slot
   assign slot_sum = {1'b0, front_ff} + {1'b0, pos};
   always_comb begin
      if (use_direct) begin
         cmd_addr = direct_addr;
      end else if (slot_sum >= (PTR_W + 1)'(DEPTH)) begin
         cmd_addr = PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH));
      end else begin
         cmd_addr = PTR_W'(slot_sum);
      end
   end

   // Build the command beat
   assign cmd_valid          = accept;
   assign cmd_value          = req_value;
   assign cmd_ctrl.kind      = kind;
   assign cmd_ctrl.status    = status;
   assign cmd_ctrl.count     = CW'(count_in);
   assign cmd_ctrl.is_empty  = (count_in == '0);

   // Hold the deque state, advance it on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rid_cmdq.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module rid_cmdq #(
   parameter int PTR_W = $clog2(rid_pkg::DEPTH_DEFAULT)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_valid,
   output      logic                         wr_full,
   input  wire rid_pkg::cmd_ctrl_type        wr_ctrl,
   input  wire logic [PTR_W-1:0]             wr_addr,
   input  wire logic [rid_pkg::VALUE_W-1:0]  wr_value,
   output      logic                         rd_valid,
   input  wire logic                         rd_take,
   output      rid_pkg::cmd_ctrl_type        rd_ctrl,
   output      logic [PTR_W-1:0]             rd_addr,
   output      logic [rid_pkg::VALUE_W-1:0]  rd_value
);

   localparam int QD  = rid_pkg::CMDQ_DEPTH;
   localparam int QP_W = $clog2(QD);
   localparam int QL_W = $clog2(QD + 1);

   rid_pkg::cmd_ctrl_type        ctrl_ff  [QD];
   logic [PTR_W-1:0]             addr_ff  [QD];
   logic [rid_pkg::VALUE_W-1:0]  value_ff [QD];
   logic [QP_W-1:0]              wptr_ff, wptr_in;
   logic [QP_W-1:0]              rptr_ff, rptr_in;
   logic [QL_W-1:0]              level_ff, level_in;
   logic                         do_wr;
   logic                         do_rd;

   assign wr_full  = (level_ff == QL_W'(QD));
   assign rd_valid = (level_ff != '0);
   assign do_wr    = wr_valid & ~wr_full;
   assign do_rd    = rd_take & rd_valid;

   assign rd_ctrl  = ctrl_ff[rptr_ff];
   assign rd_addr  = addr_ff[rptr_ff];
   assign rd_value = value_ff[rptr_ff];

   // Advance the pointers and the fill level
   always_comb begin
      wptr_in  = (wptr_ff == QP_W'(QD - 1)) ? '0 : wptr_ff + 1'b1;
      rptr_in  = (rptr_ff == QP_W'(QD - 1)) ? '0 : rptr_ff + 1'b1;
      level_in = level_ff;
      if (do_wr && !do_rd) begin
         level_in = level_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         if (do_wr) begin
            wptr_ff <= wptr_in;
         end
         if (do_rd) begin
            rptr_ff <= rptr_in;
         end
         level_ff <= level_in;
      end
   end

   // Store the entry payload
   always_ff @(posedge clock) begin
      if (do_wr) begin
         ctrl_ff[wptr_ff]  <= wr_ctrl;
         addr_ff[wptr_ff]  <= wr_addr;
         value_ff[wptr_ff] <= wr_value;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rid_back.sv =====
// Back end: element store access and the response register.
`default_nettype none
module rid_back #(
   parameter int DEPTH = rid_pkg::DEPTH_DEFAULT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   output      logic                          cmd_take,
   input  wire rid_pkg::cmd_ctrl_type         cmd_ctrl,
   input  wire logic [PTR_W-1:0]              cmd_addr,
   input  wire logic [rid_pkg::VALUE_W-1:0]   cmd_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [rid_pkg::VALUE_W-1:0]   rsp_data,
   output      logic [rid_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [rid_pkg::COUNT_W-1:0]   rsp_count,
   output      logic                          rsp_is_empty
);

   logic [rid_pkg::VALUE_W-1:0]  mem [DEPTH];
   logic [rid_pkg::VALUE_W-1:0]  rdata_ff;
   rid_pkg::cmd_ctrl_type        ctrl_ff;
   logic                         valid_ff;
   logic                         advance;

   // Take a command whenever the response slot is free or being drained
   assign advance  = ~valid_ff | ~rsp_stall;
   assign cmd_take = cmd_valid & advance;

   // Access the element store, one port
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         if (cmd_ctrl.kind == rid_pkg::KIND_WRITE) begin
            mem[cmd_addr] <= cmd_value;
         end
         if (cmd_ctrl.kind == rid_pkg::KIND_READ) begin
            rdata_ff <= mem[cmd_addr];
         end
      end
   end

   // Hold the response beat until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         ctrl_ff <= cmd_ctrl;
      end
   end

   // Drive the response fields; errors read as all ones
   assign rsp_valid    = valid_ff;
   assign rsp_status   = ctrl_ff.status;
   assign rsp_count    = ctrl_ff.count;
   assign rsp_is_empty = ctrl_ff.is_empty;
   always_comb begin
      if (ctrl_ff.status != rid_pkg::ST_OK) begin
         rsp_data = '1;
      end else if (ctrl_ff.kind == rid_pkg::KIND_READ) begin
         rsp_data = rdata_ff;
      end else begin
         rsp_data = '0;
      end
   end

endmodule
`default_nettype wire
